// File: hdl/ole_pkg.sv
package ole_pkg;

    localparam int DATA_W       = 32;
    localparam int OPCODE_W     = 4;
    localparam int POS_W        = 4;
    localparam int COUNT_OUT_W  = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SORTED_INSERT = 4'd0,
        OP_APPEND        = 4'd1,
        OP_PUSH_FRONT    = 4'd2,
        OP_POP_BACK      = 4'd3,
        OP_POP_FRONT     = 4'd4,
        OP_REMOVE_VALUE  = 4'd5,
        OP_READ_BACK     = 4'd6,
        OP_READ_FRONT    = 4'd7,
        OP_READ_INDEX    = 4'd8,
        OP_CLEAR         = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_TAKE_LEFT  = 2'd2,
        CELL_TAKE_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic ok;
        logic is_empty;
    } op_status_t;

endpackage

// File: hdl/ordered_list_engine.sv
// Each accepted input word gives its result word in the next cycle. The cell
// row compares and shifts all entries in the accept cycle and the result is
// held in an output register. Throughput: one word per cycle unless stalled.
// Reset: rst_n clears the entry count and the output valid; entry values
// are not reset and are only read below the count.
module ordered_list_engine
#(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [ole_pkg::OPCODE_W-1:0]           opcode,
    input  logic signed [ole_pkg::DATA_W-1:0]      value,
    input  logic [ole_pkg::POS_W-1:0]              position,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   ok,
    output logic signed [ole_pkg::DATA_W-1:0]      read_value,
    output logic [ole_pkg::COUNT_OUT_W-1:0]        entry_count,
    output logic                                   is_empty
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int OUT_W = (CNT_W > ole_pkg::COUNT_OUT_W) ? CNT_W : ole_pkg::COUNT_OUT_W;

    logic [CNT_W-1:0]                    cnt_reg;
    logic [CNT_W-1:0]                    cnt_next;
    logic                                out_valid_reg;
    logic                                ok_reg;
    logic signed [ole_pkg::DATA_W-1:0]   read_value_reg;
    logic [ole_pkg::COUNT_OUT_W-1:0]     entry_count_reg;
    logic                                is_empty_reg;
    logic                                accept;
    logic [OUT_W-1:0]                    cnt_ext;
    logic signed [ole_pkg::DATA_W-1:0]   rd_value;
    ole_pkg::cell_op_t                   cell_op [CAPACITY];
    ole_pkg::op_status_t                 status;
    logic [CAPACITY-1:0]                 rd_sel;
    logic [CAPACITY-1:0]                 gt_vec;
    logic [CAPACITY-1:0]                 eq_vec;
    logic signed [ole_pkg::DATA_W-1:0]   entry_vec [CAPACITY];
    logic signed [ole_pkg::DATA_W-1:0]   rd_vec [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    ole_ctrl #(.CAPACITY(CAPACITY)) u_ctrl
    (
        .go         (accept),
        .opcode     (opcode),
        .position   (position),
        .count      (cnt_reg),
        .gt_vec     (gt_vec),
        .eq_vec     (eq_vec),
        .cell_op    (cell_op),
        .rd_sel     (rd_sel),
        .count_next (cnt_next),
        .status     (status)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ole_cell u_cell
        (
            .clk         (clk),
            .op          (cell_op[i]),
            .new_value   (value),
            .left_value  ((i > 0) ? entry_vec[(i > 0) ? i-1 : 0] : value),
            .right_value ((i < CAPACITY-1) ? entry_vec[(i < CAPACITY-1) ? i+1 : i] : value),
            .rd_sel      (rd_sel[i]),
            .entry       (entry_vec[i]),
            .rd_data     (rd_vec[i]),
            .gt          (gt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_value = rd_value | rd_vec[i];
        end
    end

    assign cnt_ext = OUT_W'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
            // hold the result word while stalled, drop it once taken
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg          <= status.ok;
            read_value_reg  <= rd_value;
            entry_count_reg <= cnt_ext[ole_pkg::COUNT_OUT_W-1:0];
            is_empty_reg    <= status.is_empty;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;

endmodule

// File: hdl/ole_cell.sv
module ole_cell
(
    input  logic                                clk,
    input  ole_pkg::cell_op_t                   op,
    input  logic signed [ole_pkg::DATA_W-1:0]   new_value,
    input  logic signed [ole_pkg::DATA_W-1:0]   left_value,
    input  logic signed [ole_pkg::DATA_W-1:0]   right_value,
    input  logic                                rd_sel,
    output logic signed [ole_pkg::DATA_W-1:0]   entry,
    output logic signed [ole_pkg::DATA_W-1:0]   rd_data,
    output logic                                gt,
    output logic                                eq
);

    logic signed [ole_pkg::DATA_W-1:0] entry_reg;
    logic signed [ole_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        case (op)
            ole_pkg::CELL_LOAD:       entry_next = new_value;
            ole_pkg::CELL_TAKE_LEFT:  entry_next = left_value;
            ole_pkg::CELL_TAKE_RIGHT: entry_next = right_value;
            default:                  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign gt      = entry_reg > new_value;
    assign eq      = entry_reg == new_value;
    assign rd_data = rd_sel ? entry_reg : '0;

endmodule

// File: hdl/ole_ctrl.sv
module ole_ctrl
#(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
)
(
    input  logic                                  go,
    input  logic [ole_pkg::OPCODE_W-1:0]          opcode,
    input  logic [ole_pkg::POS_W-1:0]             position,
    input  logic [$clog2(CAPACITY+1)-1:0]         count,
    input  logic [CAPACITY-1:0]                   gt_vec,
    input  logic [CAPACITY-1:0]                   eq_vec,
    output ole_pkg::cell_op_t                     cell_op [CAPACITY],
    output logic [CAPACITY-1:0]                   rd_sel,
    output logic [$clog2(CAPACITY+1)-1:0]         count_next,
    output ole_pkg::op_status_t                   status
);

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;

    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] count_hot;
    logic [CAPACITY-1:0] sel_x;
    logic [CAPACITY-1:0] sel_ge;
    logic                full;
    logic                empty;
    logic                do_insert;
    logic                do_drop;
    logic                rd_en;
    logic                ok;
    logic [IDX_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    count_dec;
    logic [CMP_W-1:0]    pos_w;
    logic [CMP_W-1:0]    cnt_w;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_vec[i] = CNT_W'(i) < count;
            count_hot[i] = CNT_W'(i) == count;
        end
    end

    assign full      = count == CNT_W'(CAPACITY);
    assign empty     = count == '0;
    assign count_dec = count - CNT_W'(1);
    assign pos_w     = CMP_W'(position);
    assign cnt_w     = CMP_W'(count);

    always_comb
    begin
        sel_x      = '0;
        do_insert  = 1'b0;
        do_drop    = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = '0;
        ok         = 1'b0;
        count_next = count;
        unique case (ole_pkg::opcode_t'(opcode))
            ole_pkg::OP_SORTED_INSERT:
            begin
                sel_x     = (gt_vec & valid_vec) | count_hot;
                ok        = !full;
                do_insert = !full;
            end
            ole_pkg::OP_APPEND:
            begin
                sel_x     = count_hot;
                ok        = !full;
                do_insert = !full;
            end
            ole_pkg::OP_PUSH_FRONT:
            begin
                sel_x     = CAPACITY'(1);
                ok        = !full;
                do_insert = !full;
            end
            ole_pkg::OP_POP_BACK:
            begin
                ok = !empty;
            end
            ole_pkg::OP_POP_FRONT:
            begin
                sel_x   = CAPACITY'(1);
                ok      = !empty;
                do_drop = !empty;
            end
            ole_pkg::OP_REMOVE_VALUE:
            begin
                sel_x   = eq_vec & valid_vec;
                ok      = |(eq_vec & valid_vec);
                do_drop = ok;
            end
            ole_pkg::OP_READ_BACK:
            begin
                rd_idx = count_dec[IDX_W-1:0];
                ok     = !empty;
                rd_en  = ok;
            end
            ole_pkg::OP_READ_FRONT:
            begin
                ok    = !empty;
                rd_en = ok;
            end
            ole_pkg::OP_READ_INDEX:
            begin
                rd_idx = pos_w[IDX_W-1:0];
                ok     = pos_w < cnt_w;
                rd_en  = ok;
            end
            ole_pkg::OP_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (do_insert)
        begin
            count_next = count + CNT_W'(1);
        end
        if (do_drop || (ok && ole_pkg::opcode_t'(opcode) == ole_pkg::OP_POP_BACK))
        begin
            count_next = count_dec;
        end
    end

    // every position at or after the first set bit of sel_x
    assign sel_ge = sel_x | (~sel_x + CAPACITY'(1));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_op[i] = ole_pkg::CELL_HOLD;
            rd_sel[i]  = rd_en && (IDX_W'(i) == rd_idx);
            if (go && do_insert && sel_ge[i])
            begin
                if (i > 0 && sel_ge[(i > 0) ? i-1 : 0])
                begin
                    cell_op[i] = ole_pkg::CELL_TAKE_LEFT;
                end
                else
                begin
                    cell_op[i] = ole_pkg::CELL_LOAD;
                end
            end
            else if (go && do_drop && sel_ge[i] && i < CAPACITY-1)
            begin
                cell_op[i] = ole_pkg::CELL_TAKE_RIGHT;
            end
        end
    end

    assign status.ok       = ok;
    assign status.is_empty = count_next == '0;

endmodule

// File: hdl/ole_checker.sv
module ole_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               ok,
    input logic signed [ole_pkg::DATA_W-1:0]  read_value,
    input logic [ole_pkg::COUNT_OUT_W-1:0]    entry_count,
    input logic                               is_empty
);

    // a stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // every accepted word yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word gave no result");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> read_value == '0)
        else $error("failed operation returned nonzero read value");

    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no pending result");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> entry_count == '0)
        else $error("empty list reported a nonzero count");

endmodule

bind ordered_list_engine ole_checker u_ole_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .read_value  (read_value),
    .entry_count (entry_count),
    .is_empty    (is_empty)
);

// File: verif/ordered_list_engine_tb.sv
`timescale 1ns / 1ps

module ordered_list_engine_tb;

    localparam int CAP            = ole_pkg::CAPACITY_DEF;
    localparam int RANDOM_WORDS   = 700;
    localparam int PHASE_LEN      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [ole_pkg::OPCODE_W-1:0]   OP_UNUSED_LO = 4'd10;
    localparam logic [ole_pkg::OPCODE_W-1:0]   OP_UNUSED_HI = 4'd15;
    localparam logic signed [ole_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ole_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                                ok;
        logic signed [ole_pkg::DATA_W-1:0]   read_value;
        logic [ole_pkg::COUNT_OUT_W-1:0]     entry_count;
        logic                                is_empty;
    } list_result_t;

    typedef struct packed {
        logic [ole_pkg::OPCODE_W-1:0]        opcode;
        logic signed [ole_pkg::DATA_W-1:0]   value;
        logic [ole_pkg::POS_W-1:0]           position;
        logic                                fixed;
        list_result_t                        result;
    } stim_row_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_READ} phase_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [ole_pkg::OPCODE_W-1:0]        opcode = '0;
    logic signed [ole_pkg::DATA_W-1:0]   value = '0;
    logic [ole_pkg::POS_W-1:0]           position = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                ok;
    logic signed [ole_pkg::DATA_W-1:0]   read_value;
    logic [ole_pkg::COUNT_OUT_W-1:0]     entry_count;
    logic                                is_empty;

    // shadow of the list contents
    logic signed [ole_pkg::DATA_W-1:0]   list_cells [CAP];
    int                                  list_len = 0;

    list_result_t              pending_results [$];
    stim_row_t                 sent_rows [$];
    int                        err_count = 0;
    int                        idle_cycles = 0;
    int                        stall_left = 0;
    bit                        calm = 1'b0;

    ordered_list_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic place_entry(int at, logic signed [ole_pkg::DATA_W-1:0] v);
        int i;
        if (list_len >= CAP)
            return 1'b0;
        for (i = list_len; i > at; i--)
            list_cells[i] = list_cells[i-1];
        list_cells[at] = v;
        list_len++;
        return 1'b1;
    endfunction

    function automatic void drop_entry(int at);
        int i;
        for (i = at; i + 1 < list_len; i++)
            list_cells[i] = list_cells[i+1];
        list_len--;
    endfunction

    function automatic list_result_t apply_list_op(logic [ole_pkg::OPCODE_W-1:0] op,
                                                   logic signed [ole_pkg::DATA_W-1:0] v,
                                                   logic [ole_pkg::POS_W-1:0] pos);
        list_result_t r;
        int at;
        int i;
        r.ok         = 1'b0;
        r.read_value = '0;
        case (op)
            ole_pkg::OP_SORTED_INSERT:
            begin
                // scan down so the lowest index with a greater entry wins
                at = list_len;
                for (i = list_len - 1; i >= 0; i--)
                    if (list_cells[i] > v)
                        at = i;
                r.ok = place_entry(at, v);
            end
            ole_pkg::OP_APPEND:
                r.ok = place_entry(list_len, v);
            ole_pkg::OP_PUSH_FRONT:
                r.ok = place_entry(0, v);
            ole_pkg::OP_POP_BACK:
                if (list_len > 0)
                begin
                    list_len--;
                    r.ok = 1'b1;
                end
            ole_pkg::OP_POP_FRONT:
                if (list_len > 0)
                begin
                    drop_entry(0);
                    r.ok = 1'b1;
                end
            ole_pkg::OP_REMOVE_VALUE:
            begin
                at = -1;
                for (i = list_len - 1; i >= 0; i--)
                    if (list_cells[i] == v)
                        at = i;
                if (at >= 0)
                begin
                    drop_entry(at);
                    r.ok = 1'b1;
                end
            end
            ole_pkg::OP_READ_BACK:
                if (list_len > 0)
                begin
                    r.read_value = list_cells[list_len-1];
                    r.ok = 1'b1;
                end
            ole_pkg::OP_READ_FRONT:
                if (list_len > 0)
                begin
                    r.read_value = list_cells[0];
                    r.ok = 1'b1;
                end
            ole_pkg::OP_READ_INDEX:
                if (int'(pos) < list_len)
                begin
                    r.read_value = list_cells[pos];
                    r.ok = 1'b1;
                end
            ole_pkg::OP_CLEAR:
            begin
                list_len = 0;
                r.ok = 1'b1;
            end
            default:
                ;
        endcase
        r.entry_count = list_len[ole_pkg::COUNT_OUT_W-1:0];
        r.is_empty    = (list_len == 0);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [ole_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return int'($urandom_range(0, 8)) - 4;
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic stim_row_t make_row(logic [ole_pkg::OPCODE_W-1:0] op,
                                           logic signed [ole_pkg::DATA_W-1:0] v,
                                           logic [ole_pkg::POS_W-1:0] pos, logic fixed,
                                           logic want_ok,
                                           logic signed [ole_pkg::DATA_W-1:0] want_rd,
                                           logic [ole_pkg::COUNT_OUT_W-1:0] want_cnt,
                                           logic want_empty);
        stim_row_t row;
        row.opcode             = op;
        row.value              = v;
        row.position           = pos;
        row.fixed              = fixed;
        row.result.ok          = want_ok;
        row.result.read_value  = want_rd;
        row.result.entry_count = want_cnt;
        row.result.is_empty    = want_empty;
        return row;
    endfunction

    task automatic send_word(stim_row_t row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sent_rows.push_back(row);
        in_valid <= 1'b1;
        opcode   <= row.opcode;
        value    <= row.value;
        position <= row.position;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : scoreboard
        list_result_t want;
        list_result_t pred;
        stim_row_t    row;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result word with nothing pending");
                else
                begin
                    want = pending_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch($sformatf("ok got %b exp %b", ok, want.ok));
                    if (read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %0d exp %0d",
                                                  read_value, want.read_value));
                    if (entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d exp %0d",
                                                  entry_count, want.entry_count));
                    if (is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %b exp %b",
                                                  is_empty, want.is_empty));
                end
            end
            if (in_valid && !in_stall)
            begin
                row  = sent_rows.pop_front();
                pred = apply_list_op(opcode, value, position);
                pending_results.push_back(row.fixed ? row.result : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        stim_row_t                           directed [$];
        logic signed [ole_pkg::DATA_W-1:0]   recent [8];
        phase_t                              phase;
        logic [ole_pkg::OPCODE_W-1:0]        op;
        logic signed [ole_pkg::DATA_W-1:0]   v;
        logic [ole_pkg::POS_W-1:0]           pos;
        int                                  r;
        int                                  n;
        int                                  slot;

        for (n = 0; n < 8; n++)
            recent[n] = 0;
        slot  = 0;
        phase = PH_FILL;

        // empty list first, then extremes, then error cases
        directed.push_back(make_row(ole_pkg::OP_READ_FRONT, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_POP_BACK, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_POP_FRONT, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_READ_BACK, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_READ_INDEX, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_REMOVE_VALUE, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_SORTED_INSERT, 0, 0, 1, 1, 0, 1, 0));
        directed.push_back(make_row(ole_pkg::OP_SORTED_INSERT, VAL_MAX, 0, 1, 1, 0, 2, 0));
        directed.push_back(make_row(ole_pkg::OP_SORTED_INSERT, VAL_MIN, 15, 1, 1, 0, 3, 0));
        directed.push_back(make_row(ole_pkg::OP_READ_FRONT, 0, 0, 1, 1, VAL_MIN, 3, 0));
        directed.push_back(make_row(ole_pkg::OP_READ_BACK, 0, 0, 1, 1, VAL_MAX, 3, 0));
        directed.push_back(make_row(ole_pkg::OP_SORTED_INSERT, -1, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_SORTED_INSERT, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_APPEND, 5, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_PUSH_FRONT, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_READ_INDEX, 0, 15, 1, 0, 0, 7, 0));
        directed.push_back(make_row(ole_pkg::OP_READ_INDEX, 0, 2, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_REMOVE_VALUE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_REMOVE_VALUE, 12345, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_POP_FRONT, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_POP_BACK, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_UNUSED_LO, 7, 1, 0, 0, 0, 0, 0));
        directed.push_back(make_row(OP_UNUSED_HI, -7, 14, 0, 0, 0, 0, 0));
        directed.push_back(make_row(ole_pkg::OP_CLEAR, 0, 0, 1, 1, 0, 0, 1));
        directed.push_back(make_row(ole_pkg::OP_CLEAR, 0, 0, 1, 1, 0, 0, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i]);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase = phase_t'($urandom_range(0, 3));
                calm  = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                op = ole_pkg::OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
            begin
                case (phase)
                    PH_FILL:
                        if (r < 45)
                            op = ole_pkg::OP_SORTED_INSERT;
                        else if (r < 60)
                            op = ole_pkg::OP_APPEND;
                        else if (r < 75)
                            op = ole_pkg::OP_PUSH_FRONT;
                        else
                            op = ole_pkg::OPCODE_W'($urandom_range(ole_pkg::OP_POP_BACK,
                                                                   ole_pkg::OP_READ_INDEX));
                    PH_DRAIN:
                        if (r < 30)
                            op = ole_pkg::OP_POP_BACK;
                        else if (r < 55)
                            op = ole_pkg::OP_POP_FRONT;
                        else if (r < 80)
                            op = ole_pkg::OP_REMOVE_VALUE;
                        else
                            op = ole_pkg::OPCODE_W'($urandom_range(ole_pkg::OP_SORTED_INSERT,
                                                                   ole_pkg::OP_PUSH_FRONT));
                    PH_READ:
                        if (r < 60)
                            op = ole_pkg::OPCODE_W'($urandom_range(ole_pkg::OP_READ_BACK,
                                                                   ole_pkg::OP_READ_INDEX));
                        else if (r < 80)
                            op = ole_pkg::OPCODE_W'($urandom_range(ole_pkg::OP_SORTED_INSERT,
                                                                   ole_pkg::OP_PUSH_FRONT));
                        else
                            op = ole_pkg::OPCODE_W'($urandom_range(ole_pkg::OP_POP_BACK,
                                                                   ole_pkg::OP_REMOVE_VALUE));
                    default:
                    begin
                        op = ole_pkg::OPCODE_W'($urandom_range(ole_pkg::OP_SORTED_INSERT,
                                                               ole_pkg::OP_CLEAR));
                        // keep clears rare so the list gets a chance to fill
                        if (op == ole_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
                            op = ole_pkg::OP_SORTED_INSERT;
                    end
                endcase
            end

            if (op == ole_pkg::OP_REMOVE_VALUE && $urandom_range(0, 2) != 0)
                v = recent[3'($urandom_range(0, 7))];
            else
                v = pick_value();
            if (op == ole_pkg::OP_SORTED_INSERT || op == ole_pkg::OP_APPEND ||
                op == ole_pkg::OP_PUSH_FRONT)
            begin
                recent[slot] = v;
                slot = (slot + 1) % 8;
            end
            pos = ($urandom_range(0, 1) == 0) ? ole_pkg::POS_W'($urandom_range(0, 3))
                                              : ole_pkg::POS_W'($urandom_range(0, 15));

            send_word(make_row(op, v, pos, 0, 0, 0, 0, 0));
        end

        calm = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || sent_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
